[rtl/svt_pkg.sv]
`timescale 1ns / 1ps

package svt_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int IDX_W           = 6;
  localparam int OP_W            = 2;
  localparam int ST_W            = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } ctl_t;

endpackage

[rtl/svt_cell.sv]
`timescale 1ns / 1ps

module svt_cell #(
  parameter int VALUE_WIDTH = svt_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = 7,
  parameter int CMP_W       = 7,
  parameter int POS         = 0
) (
  input  logic                          clk,
  input  svt_pkg::ctl_t                 ctl,
  input  logic        [CNT_W-1:0]       count,
  input  logic        [CMP_W-1:0]       idx,
  input  logic signed [VALUE_WIDTH-1:0] add_value,
  input  logic                          m_left,
  input  logic signed [VALUE_WIDTH-1:0] e_left,
  input  logic signed [VALUE_WIDTH-1:0] e_right,
  output logic                          m_out,
  output logic signed [VALUE_WIDTH-1:0] e_out,
  output logic        [VALUE_WIDTH-1:0] rd_out
);

  localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(POS);
  localparam logic [CMP_W-1:0] POS_IDX = CMP_W'(POS);

  logic signed [VALUE_WIDTH-1:0] e_r;
  logic signed [VALUE_WIDTH-1:0] e_nxt;

  // set from the insert point onwards; unused cells count as larger
  assign m_out = (POS_CNT >= count) || (e_r > add_value);
  assign e_out = e_r;
  assign rd_out = (idx == POS_IDX) ? e_r : '0;

  always_comb begin
    e_nxt = e_r;
    if (ctl.ins_en && m_out) begin
      e_nxt = m_left ? e_left : add_value;
    end else if (ctl.rem_en && (POS_IDX >= idx)) begin
      e_nxt = e_right;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

endmodule

[rtl/sorted_value_table.sv]
`timescale 1ns / 1ps
// Sorted value table: keeps up to CAPACITY signed words in ascending order.
// Input channel (in_valid/in_ready) carries one command word: opcode, value,
// index. Insert places the value after any equal entries (dropped with
// status 1 when full), remove deletes the entry at index, read returns it.
// An index at or past the entry count gives status 2 (read returns -1).
// Result channel (out_valid/out_ready) carries read_value, entry_count and
// status, exactly one result word per command.
// out_valid rises in the cycle after acceptance. Throughput: one command per
// cycle while results drain; every cell compares and shifts in the same cycle.
// The result sits in an output register; while it is held by a stalled
// receiver, in_ready stays high only if out_ready is high in that cycle.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; entry storage itself is not cleared and needs no clearing pass.
module sorted_value_table #(
  parameter int CAPACITY    = svt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = svt_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [svt_pkg::OP_W-1:0]         in_opcode,
  input  logic signed [VALUE_WIDTH-1:0]    in_value,
  input  logic [svt_pkg::IDX_W-1:0]        in_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [VALUE_WIDTH-1:0]    out_read_value,
  output logic [CNT_W-1:0]                 out_entry_count,
  output logic [svt_pkg::ST_W-1:0]         out_status
);

  localparam int CMP_W = (CNT_W > svt_pkg::IDX_W) ? CNT_W : svt_pkg::IDX_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  svt_pkg::status_t              st_r, st_nxt;

  logic             acc;
  svt_pkg::op_t     op;
  svt_pkg::ctl_t    ctl;
  logic [CMP_W-1:0] idx_ext;
  logic             full;
  logic             in_range;

  logic                          m_w  [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] e_w  [CAPACITY];
  logic        [VALUE_WIDTH-1:0] rd_w [CAPACITY];
  logic        [VALUE_WIDTH-1:0] rd_or;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign op       = svt_pkg::op_t'(in_opcode);
  assign idx_ext  = CMP_W'(in_index);
  assign full     = (count_r == CAP_CNT);
  assign in_range = (idx_ext < CMP_W'(count_r));

  assign ctl.ins_en = acc && (op == svt_pkg::OP_INSERT) && !full;
  assign ctl.rem_en = acc && (op == svt_pkg::OP_REMOVE) && in_range;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    svt_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .CMP_W       (CMP_W),
      .POS         (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .idx       (idx_ext),
      .add_value (in_value),
      .m_left    ((i == 0) ? 1'b0 : m_w[(i == 0) ? 0 : i - 1]),
      .e_left    (e_w[(i == 0) ? 0 : i - 1]),
      .e_right   (e_w[(i == CAPACITY - 1) ? i : i + 1]),
      .m_out     (m_w[i]),
      .e_out     (e_w[i]),
      .rd_out    (rd_w[i])
    );
  end

  // one cell matches the index at most; the others give zero
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_w[i];
    end
  end

  always_comb begin
    rd_nxt    = '0;
    st_nxt    = svt_pkg::ST_DONE;
    count_nxt = count_r;
    case (op)
      svt_pkg::OP_INSERT: begin
        if (full) begin
          st_nxt = svt_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      svt_pkg::OP_REMOVE: begin
        if (in_range) begin
          count_nxt = count_r - 1'b1;
        end else begin
          st_nxt = svt_pkg::ST_RANGE;
        end
      end
      svt_pkg::OP_READ: begin
        if (in_range) begin
          rd_nxt = rd_or;
        end else begin
          rd_nxt = '1;
          st_nxt = svt_pkg::ST_RANGE;
        end
      end
      default: begin
        rd_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (acc) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= rd_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = rd_r;
  assign out_entry_count = count_r;
  assign out_status      = st_r;

endmodule

[rtl/svt_checker.sv]
`timescale 1ns / 1ps

module svt_checker #(
  parameter int CAPACITY    = svt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = svt_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = $clog2(CAPACITY + 1)
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [VALUE_WIDTH-1:0] out_read_value,
  input logic [CNT_W-1:0]              out_entry_count,
  input logic [svt_pkg::ST_W-1:0]      out_status
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_entry_count) && $stable(out_status))
    else $error("result word changed while stalled");

  a_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted command gave no result");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == svt_pkg::ST_FULL) |->
      (out_entry_count == CAP_CNT) && (out_read_value == '0))
    else $error("dropped insert with table not full");

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CAP_CNT))
    else $error("entry count beyond capacity");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_value_table svt_checker #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH),
  .CNT_W       (CNT_W)
) u_svt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_read_value  (out_read_value),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);
